FILE: hw/rtl/bfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfe_pkg
// Shared types and constants for the battery failsafe escalation block.
// ----------------------------------------------------------------------------
package bfe_pkg;

    localparam int unsigned US_PER_MS = 1000;
    localparam int unsigned DEBOUNCE_W = 16;
    // 65535 ms * 1000 fits in 26 bits
    localparam int unsigned GRACE_W = 26;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned POS_W = 8;
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    localparam logic [POS_W-1:0] POS_UNSET = 8'hFF;

    localparam logic [1:0] LEVEL_NONE     = 2'd0;
    localparam logic [1:0] LEVEL_WARNING  = 2'd1;
    localparam logic [1:0] LEVEL_CRITICAL = 2'd2;

    localparam logic [1:0] REG_DEBOUNCE_MS       = 2'd0;
    localparam logic [1:0] REG_CRITICAL_POSITION = 2'd1;
    localparam logic [1:0] REG_WARNING_POSITION  = 2'd2;

    typedef struct packed {
        logic                is_armed;
        logic [1:0]          alarm_level;
        logic [POS_W-1:0]    switch_position;
        logic [STAMP_W-1:0]  now_us;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]    effective_position;
        logic [1:0]          failsafe_level;
        logic                override_active;
    } result_t;

    typedef struct packed {
        logic [GRACE_W-1:0]      grace_us;
        logic signed [POS_W-1:0] critical_position;
        logic signed [POS_W-1:0] warning_position;
    } cfg_t;

endpackage

FILE: hw/rtl/bfe_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfe_cfg
// APB register file; keeps the debounce time prescaled to microseconds.
// ----------------------------------------------------------------------------
module bfe_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bfe_pkg::PADDR_W-1:0]    paddr,
    input  logic [bfe_pkg::PDATA_W-1:0]    pwdata,
    output logic [bfe_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    output bfe_pkg::cfg_t                  cfg
);
    import bfe_pkg::*;

    logic [DEBOUNCE_W-1:0]   debounce_ms_reg;
    logic [GRACE_W-1:0]      grace_reg;
    logic signed [POS_W-1:0] critical_position_reg;
    logic signed [POS_W-1:0] warning_position_reg;
    logic                    wr_en;
    logic [1:0]              reg_sel;
    logic [GRACE_W-1:0]      grace_next;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[PADDR_W-1:2];
    // constant multiply; the product is stored only on a debounce register write
    assign grace_next = GRACE_W'(pwdata[DEBOUNCE_W-1:0]) * GRACE_W'(US_PER_MS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg       <= '0;
            grace_reg             <= '0;
            critical_position_reg <= POS_UNSET;
            warning_position_reg  <= POS_UNSET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_DEBOUNCE_MS:
                begin
                    debounce_ms_reg <= pwdata[DEBOUNCE_W-1:0];
                    grace_reg       <= grace_next;
                end
                REG_CRITICAL_POSITION: critical_position_reg <= pwdata[POS_W-1:0];
                REG_WARNING_POSITION:  warning_position_reg  <= pwdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // return the stored bits of each register, zero extended; other addresses read zero
    always_comb
    begin
        unique case (reg_sel)
            REG_DEBOUNCE_MS:       prdata = PDATA_W'(debounce_ms_reg);
            REG_CRITICAL_POSITION: prdata = {{(PDATA_W-POS_W){1'b0}}, critical_position_reg};
            REG_WARNING_POSITION:  prdata = {{(PDATA_W-POS_W){1'b0}}, warning_position_reg};
            default:               prdata = '0;
        endcase
    end

    assign cfg.grace_us          = grace_reg;
    assign cfg.critical_position = critical_position_reg;
    assign cfg.warning_position  = warning_position_reg;

endmodule

FILE: hw/rtl/bfe_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfe_step
// Escalation state and the per-transaction latch / override decision.
// ----------------------------------------------------------------------------
module bfe_step (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  bfe_pkg::item_t   item,
    input  bfe_pkg::cfg_t    cfg,
    output bfe_pkg::result_t res
);
    import bfe_pkg::*;

    logic [1:0]         latched_level_reg, latched_level_next;
    logic               overridden_reg, overridden_next;
    logic [POS_W-1:0]   position_at_latch_reg, position_at_latch_next;
    logic [STAMP_W-1:0] change_stamp_reg, change_stamp_next;

    logic [1:0]         level;
    logic [STAMP_W-1:0] elapsed;
    logic               in_grace;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_level_reg     <= LEVEL_NONE;
            overridden_reg        <= 1'b0;
            position_at_latch_reg <= '0;
            change_stamp_reg      <= '0;
        end
        else if (fire)
        begin
            latched_level_reg     <= latched_level_next;
            overridden_reg        <= overridden_next;
            position_at_latch_reg <= position_at_latch_next;
            change_stamp_reg      <= change_stamp_next;
        end
    end

    // alarm code three counts as none
    assign level = (item.alarm_level == LEVEL_WARNING || item.alarm_level == LEVEL_CRITICAL)
                   ? item.alarm_level : LEVEL_NONE;
    assign elapsed  = item.now_us - change_stamp_reg;
    assign in_grace = elapsed < STAMP_W'(cfg.grace_us);

    always_comb
    begin
        latched_level_next     = latched_level_reg;
        overridden_next        = overridden_reg;
        position_at_latch_next = position_at_latch_reg;
        change_stamp_next      = change_stamp_reg;
        res.effective_position = item.switch_position;
        res.failsafe_level     = LEVEL_NONE;
        res.override_active    = 1'b0;

        if (!item.is_armed)
        begin
            latched_level_next     = LEVEL_NONE;
            overridden_next        = 1'b0;
            change_stamp_next      = item.now_us;
            position_at_latch_next = item.switch_position;
        end
        else
        begin
            // debounce: restart the timer while the alarm matches the latch
            priority if (level == latched_level_reg)
            begin
                change_stamp_next = item.now_us;
            end
            else if (in_grace || level < latched_level_reg)
            begin
                // hold
            end
            else
            begin
                latched_level_next     = level;
                position_at_latch_next = item.switch_position;
                overridden_next        = 1'b0;
            end

            if (latched_level_next != LEVEL_NONE && !overridden_next)
            begin
                priority if (position_at_latch_next != item.switch_position)
                begin
                    overridden_next   = 1'b1;
                    change_stamp_next = item.now_us;
                end
                else if (latched_level_next == LEVEL_CRITICAL
                         && cfg.critical_position != POS_UNSET)
                begin
                    res.effective_position = cfg.critical_position;
                end
                else if (cfg.warning_position != POS_UNSET)
                begin
                    res.effective_position = cfg.warning_position;
                end
                else
                begin
                    // pass the switch through
                end
            end

            res.failsafe_level  = latched_level_next;
            res.override_active = overridden_next;
        end
    end

endmodule

FILE: hw/rtl/battery_failsafe_escalation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_failsafe_escalation_top
// Battery alarm failsafe: debounced level latch and mode switch substitution.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall / item) carries one sample per
//   transaction: armed flag, alarm level, switch position and a microsecond
//   timestamp. The output channel (result_valid / result_stall / result)
//   returns exactly one result per input transaction, in order.
//   Path: an accepted transaction is held in the input register, and its
//   result is then held in the result register until it is taken.
//   Throughput: one transaction per cycle while the output does not stall;
//   stages: input register, single decision pass and result register only.
//   Stall: a stalled result holds in the result register; the input
//   register still takes one more transaction, then item_stall rises
//   until the result is taken.
//   Reset (rst_n low, asynchronous) empties both registers, clears the
//   latched level, override flag, latch position and timestamp, and sets
//   debounce to 0 and both forced positions to unset.
//   Configuration goes through the APB port (0x0, 0x4, 0x8); the user must
//   write it only while no transaction is in flight, unenforced by the block.
// ----------------------------------------------------------------------------
module battery_failsafe_escalation_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  bfe_pkg::item_t                 item,
    output logic                           result_valid,
    input  logic                           result_stall,
    output bfe_pkg::result_t               result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bfe_pkg::PADDR_W-1:0]    paddr,
    input  logic [bfe_pkg::PDATA_W-1:0]    pwdata,
    output logic [bfe_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import bfe_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    logic    result_valid_reg;
    result_t step_res;
    logic    fire;
    logic    take;

    bfe_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // advance the held transaction when the result register is free
    assign fire       = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !fire;
    assign take       = item_valid && !item_stall;

    bfe_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (step_res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
    end

    // result register: hold while stalled, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= step_res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: hw/rtl/bfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfe_checker
// Port-level checks for the battery failsafe escalation block.
// ----------------------------------------------------------------------------
module bfe_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input logic             result_valid,
    input logic             result_stall,
    input bfe_pkg::result_t result
);
    import bfe_pkg::*;

    // an override only exists on top of a latched level
    a_override_needs_level: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.override_active |-> result.failsafe_level != LEVEL_NONE)
        else $error("override reported with no latched level");

    // an accepted transaction reaches the output via the input and result registers if not stalled
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) ##1 !result_stall |=> result_valid)
        else $error("result missing two cycles after accept");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

endmodule

bind battery_failsafe_escalation_top bfe_checker u_bfe_checker (.*);

FILE: tb/sv/battery_failsafe_escalation_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_failsafe_escalation_top_tb
// Self-checking bench for the battery failsafe escalation block.
// A queue of flight samples feeds a clocked driver. A clocked monitor predicts
// each accepted transaction's output and checks every returned result against
// that prediction in order. Registers are reprogrammed between phases while
// the block is idle, and the source and sink idle at changing rates.
// ----------------------------------------------------------------------------
module battery_failsafe_escalation_top_tb;

    import bfe_pkg::*;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;

    logic            item_valid = 1'b0;
    logic            item_stall;
    item_t           item = '0;
    logic            result_valid;
    logic            result_stall = 1'b0;
    result_t         result;

    logic            psel = 1'b0;
    logic            penable = 1'b0;
    logic            pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic            pready;

    battery_failsafe_escalation_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Flight samples waiting to be sent, and the outputs predicted for the
    // samples the block has taken but not yet answered.
    item_t   flight_samples[$];
    result_t failsafe_outputs[$];

    int samples_queued = 0;
    int outputs_matched = 0;
    int error_count = 0;

    // Idle rates in percent for the source and the sink.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Set at each rising edge when the block took the transaction on the bus.
    logic item_taken = 1'b0;

    // Register shadow, written alongside every APB write.
    logic [DEBOUNCE_W-1:0] cfg_debounce = '0;
    logic [POS_W-1:0]      cfg_critical = POS_UNSET;
    logic [POS_W-1:0]      cfg_warning = POS_UNSET;

    // Escalation state as the block should hold it.
    logic [1:0]         held_level = LEVEL_NONE;
    logic               pilot_override = 1'b0;
    logic [POS_W-1:0]   latch_position = '0;
    logic [STAMP_W-1:0] level_stamp = '0;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Generous ceiling on the whole run; a correct run ends far earlier.
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor: debounced latch, substitution and pilot override
    // ------------------------------------------------------------------------
    function automatic logic [STAMP_W-1:0] grace_window();
        return STAMP_W'(cfg_debounce) * US_PER_MS;
    endfunction

    function automatic result_t predict_failsafe(item_t s);
        result_t             r;
        logic [1:0]          level;
        logic [STAMP_W-1:0]  elapsed;
        r.effective_position = s.switch_position;
        r.failsafe_level     = LEVEL_NONE;
        r.override_active    = 1'b0;
        // Disarmed: clear everything and remember where the switch sits now.
        if (!s.is_armed)
        begin
            held_level     = LEVEL_NONE;
            pilot_override = 1'b0;
            level_stamp    = s.now_us;
            latch_position = s.switch_position;
            return r;
        end
        // Code three counts as no alarm.
        level = (s.alarm_level == LEVEL_WARNING || s.alarm_level == LEVEL_CRITICAL)
                ? s.alarm_level : LEVEL_NONE;
        elapsed = s.now_us - level_stamp;
        if (level == held_level)
            level_stamp = s.now_us;
        else if (!(elapsed < grace_window() || level < held_level))
        begin
            held_level     = level;
            latch_position = s.switch_position;
            pilot_override = 1'b0;
        end
        if (held_level != LEVEL_NONE && !pilot_override)
        begin
            if (latch_position != s.switch_position)
            begin
                pilot_override = 1'b1;
                level_stamp    = s.now_us;
            end
            else if (held_level == LEVEL_CRITICAL && cfg_critical != POS_UNSET)
                r.effective_position = cfg_critical;
            else if (cfg_warning != POS_UNSET)
                r.effective_position = cfg_warning;
        end
        r.failsafe_level  = held_level;
        r.override_active = pilot_override;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: advance at the falling edge, hold a transaction until taken
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || item_taken)
            begin
                if (flight_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item       <= flight_samples.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on input handshakes, check on output handshakes
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
            item_taken <= 1'b0;
        else
        begin
            item_taken <= item_valid && !item_stall;
            if (item_valid && !item_stall)
                failsafe_outputs.push_back(predict_failsafe(item));
            if (result_valid && !result_stall)
            begin
                if (failsafe_outputs.size() == 0)
                begin
                    if (error_count < 10)
                        $display("%0t: unexpected result pos=%0d level=%0d ovr=%0d",
                                 $realtime, result.effective_position,
                                 result.failsafe_level, result.override_active);
                    error_count++;
                end
                else
                begin
                    want = failsafe_outputs.pop_front();
                    outputs_matched++;
                    if (result.effective_position !== want.effective_position ||
                        result.failsafe_level !== want.failsafe_level ||
                        result.override_active !== want.override_active)
                    begin
                        if (error_count < 10)
                            $display("%0t: mismatch exp/act pos %0d/%0d lvl %0d/%0d ovr %0d/%0d",
                                     $realtime,
                                     want.effective_position, result.effective_position,
                                     want.failsafe_level, result.failsafe_level,
                                     want.override_active, result.override_active);
                        error_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_sample(logic armed, logic [1:0] alarm, logic [POS_W-1:0] pos,
                                logic [STAMP_W-1:0] stamp);
        item_t s;
        s.is_armed        = armed;
        s.alarm_level     = alarm;
        s.switch_position = pos;
        s.now_us          = stamp;
        flight_samples.push_back(s);
        samples_queued++;
    endtask

    // Two-phase APB write, then a read back of the same register; the shadow
    // follows once the write access completes.
    task automatic write_register(logic [1:0] index, logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] readback_want;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_DEBOUNCE_MS:
            begin
                cfg_debounce  = data[DEBOUNCE_W-1:0];
                readback_want = PDATA_W'(data[DEBOUNCE_W-1:0]);
            end
            REG_CRITICAL_POSITION:
            begin
                cfg_critical  = data[POS_W-1:0];
                readback_want = PDATA_W'(data[POS_W-1:0]);
            end
            REG_WARNING_POSITION:
            begin
                cfg_warning   = data[POS_W-1:0];
                readback_want = PDATA_W'(data[POS_W-1:0]);
            end
            default: readback_want = '0;
        endcase
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== readback_want)
        begin
            if (error_count < 10)
                $display("%0t: register %0d read back %0h, expected %0h",
                         $realtime, index, prdata, readback_want);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_failsafe(int debounce, int critical, int warning);
        write_register(REG_DEBOUNCE_MS, PDATA_W'(debounce));
        write_register(REG_CRITICAL_POSITION, PDATA_W'(critical));
        write_register(REG_WARNING_POSITION, PDATA_W'(warning));
    endtask

    // Wait until every queued sample has been answered, then let the
    // pipeline settle before touching registers again.
    task automatic wait_for_quiet();
        while (outputs_matched < samples_queued)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Time advance between samples: half the time within the debounce window, often
    // right at its edge, now and then a jump anywhere (wrapping the clock).
    function automatic logic [STAMP_W-1:0] clock_step();
        logic [STAMP_W-1:0] grace;
        grace = grace_window();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return STAMP_W'($urandom_range(grace / 4 + 50));
            5, 6:          return grace + STAMP_W'($urandom_range(2)) - 1;
            7, 8:          return STAMP_W'($urandom_range(2 * grace + 100));
            default:       return $urandom();
        endcase
    endfunction

    // Mostly well-formed flights: a disarmed lead-in, then an armed stretch
    // with an escalating alarm and a steady switch, plus bursts of noise.
    task automatic queue_flights(int count);
        logic [STAMP_W-1:0] stamp;
        logic [POS_W-1:0]   home;
        logic [POS_W-1:0]   pos;
        logic [1:0]         alarm;
        int                 made;
        stamp = $urandom();
        made  = 0;
        while (made < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                repeat ($urandom_range(1, 5))
                begin
                    queue_sample(1'($urandom_range(1)), 2'($urandom_range(3)),
                                 POS_W'($urandom_range(255)), $urandom());
                    made++;
                end
            end
            else
            begin
                home  = POS_W'($urandom_range(255));
                alarm = LEVEL_NONE;
                repeat ($urandom_range(1, 3))
                begin
                    stamp += clock_step();
                    queue_sample(1'b0, 2'($urandom_range(3)), home, stamp);
                    made++;
                end
                repeat ($urandom_range(5, 40))
                begin
                    stamp += clock_step();
                    case ($urandom_range(19))
                        0, 1, 2: if (alarm != LEVEL_CRITICAL) alarm = alarm + 2'd1;
                        3:       alarm = 2'($urandom_range(3));
                        default: ;
                    endcase
                    pos = home;
                    case ($urandom_range(19))
                        // pilot moves the switch and leaves it there
                        0:
                        begin
                            home = POS_W'($urandom_range(255));
                            pos  = home;
                        end
                        // one-off glitch on the switch
                        1: pos = POS_W'($urandom_range(255));
                        default: ;
                    endcase
                    queue_sample(1'b1, alarm, pos, stamp);
                    made++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [STAMP_W-1:0] t0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 27;
        recv_idle_pct = 67;

        // Directed: 2 ms debounce, critical 10, warning 20. Start just below
        // the clock wrap so the debounce window straddles it.
        program_failsafe(2, 10, 20);
        t0 = 32'hFFFF_FC00;
        queue_sample(1'b0, LEVEL_NONE,     8'd5,   t0);
        queue_sample(1'b1, LEVEL_WARNING,  8'd5,   t0 + 100);
        queue_sample(1'b1, LEVEL_WARNING,  8'd5,   t0 + 1999);  // last us of grace
        queue_sample(1'b1, LEVEL_WARNING,  8'd5,   t0 + 2000);  // latch warning
        queue_sample(1'b1, 2'd3,           8'd5,   t0 + 2500);  // code three: no alarm
        queue_sample(1'b1, LEVEL_CRITICAL, 8'd5,   t0 + 3000);  // escalate
        queue_sample(1'b1, LEVEL_NONE,     8'd5,   t0 + 3100);  // never drops
        queue_sample(1'b1, LEVEL_CRITICAL, 8'd6,   t0 + 3200);  // pilot override
        queue_sample(1'b1, LEVEL_CRITICAL, 8'd5,   t0 + 3300);  // stays overridden
        queue_sample(1'b0, LEVEL_CRITICAL, 8'd200, t0 + 4000);  // disarm clears
        queue_sample(1'b1, LEVEL_CRITICAL, 8'd200, t0 + 4000);
        queue_sample(1'b1, LEVEL_CRITICAL, 8'd200, t0 + 5999);
        queue_sample(1'b1, LEVEL_CRITICAL, 8'd200, t0 + 6000);  // straight to critical
        wait_for_quiet();

        // Directed: no debounce, critical unset so warning (-5 -> 251) stands in.
        program_failsafe(0, -1, -5);
        queue_sample(1'b0, LEVEL_NONE,     8'd255, 32'hFFFF_FFFF);
        queue_sample(1'b1, LEVEL_CRITICAL, 8'd255, 32'h0000_0000);
        queue_sample(1'b1, LEVEL_WARNING,  8'd255, 32'h0000_0000);
        queue_sample(1'b1, LEVEL_NONE,     8'd0,   32'hFFFF_FFFF);
        queue_sample(1'b0, LEVEL_NONE,     8'd0,   32'h0000_0000);
        queue_sample(1'b1, LEVEL_WARNING,  8'd0,   32'h8000_0000);
        wait_for_quiet();

        // Random flights under a spread of register settings and idle rates.
        program_failsafe(0, -1, -1);
        queue_flights(330);
        wait_for_quiet();

        program_failsafe(65535, 127, 0);
        queue_flights(330);
        wait_for_quiet();

        send_idle_pct = 67;
        recv_idle_pct = 27;
        program_failsafe(1, -128, 127);
        queue_flights(330);
        wait_for_quiet();

        program_failsafe(5, -1, 100);
        queue_flights(330);
        wait_for_quiet();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_failsafe(3, 0, -1);
        queue_flights(330);
        wait_for_quiet();

        program_failsafe(65535, -2, -1);
        queue_flights(330);
        wait_for_quiet();

        // Anything still predicted here never came back.
        if (failsafe_outputs.size() != 0)
            error_count++;

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
